### hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the unit vector Jacobian block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define UVJ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define UVJ_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/uvj_pkg.sv
// Package of types, widths and register codes for the unit vector Jacobian block.
package uvj_pkg;

  localparam int unsigned COORD_W    = 32;  // coordinates, density, entries
  localparam int unsigned DIFF_W     = 33;  // magnitude of a coordinate difference
  localparam int unsigned SQ_W       = 65;  // product of two differences
  localparam int unsigned SUM_W      = 66;  // sum of the two squares
  localparam int unsigned LIM_W      = 31;  // distance limit
  localparam int unsigned LIMSQ_W    = 62;  // squared distance limit
  localparam int unsigned RATIO_W    = 33;  // product over sum in 1.32 form
  localparam int unsigned ROOT_W     = 49;  // root of the sum with 16 extra fraction bits
  localparam int unsigned SCALED_W   = 65;  // density times ratio
  localparam int unsigned MAG_W      = 32;  // magnitude quotient bits
  localparam int unsigned ROOT_STEPS  = ROOT_W;
  localparam int unsigned RATIO_STEPS = RATIO_W;
  localparam int unsigned MAG_STEPS   = MAG_W;
  localparam int unsigned UVJ_FIFO_DEPTH = 4;

  // Register indexes of the configuration channel.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIM = 8'd3;

  localparam logic [COORD_W-1:0] DENSITY_RESET = 32'h0001_0000;
  localparam logic [COORD_W-1:0] POS_LIMIT     = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_LIMIT     = 32'h8000_0000;

  // Entry order inside the lane arrays.
  localparam int unsigned LANE_XX = 0;
  localparam int unsigned LANE_XY = 1;
  localparam int unsigned LANE_YY = 2;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] density;
    logic [LIMSQ_W-1:0] lim_sq;
  } uvj_cfg_t;

  // Classified point handed from the front end to the back end.
  typedef struct packed {
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] b;
    logic              neg;
  } uvj_item_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] prod;
    logic                 neg;
  } uvj_prod_t;

  typedef struct packed {
    logic [SUM_W-1:0]     s;
    logic [2:0][SQ_W-1:0] prod;
    logic                 neg;
    logic                 zero;
  } uvj_sum_t;

  // State of one root and ratio step.
  typedef struct packed {
    logic [SUM_W-1:0]        s;
    logic [ROOT_W+1:0]       srem;
    logic [ROOT_W-1:0]       root;
    logic [2:0][SUM_W-1:0]   drem;
    logic [2:0][RATIO_W-1:0] quo;
    logic                    neg;
    logic                    zero;
  } uvj_rs_t;

  typedef struct packed {
    logic [2:0][SCALED_W-1:0] t;
    logic [ROOT_W-1:0]        root;
    logic                     neg;
    logic                     zero;
  } uvj_mg_t;

  // State of one magnitude division step.
  typedef struct packed {
    logic [ROOT_W-1:0]        root;
    logic [2:0][ROOT_W-1:0]   rem;
    logic [2:0][MAG_W-1:0]    tlo;
    logic [2:0][MAG_W-1:0]    q;
    logic [2:0]               ovf;
    logic                     neg;
    logic                     zero;
  } uvj_md_t;

endpackage

### hdl/uvj_fifo.sv
// Short queue between the front end and the back end.
`include "assert_macros.svh"

module uvj_fifo #(
  parameter int unsigned DEPTH = uvj_pkg::UVJ_FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uvj_pkg::uvj_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output uvj_pkg::uvj_item_t item_o,
  output logic              valid_o
);
  import uvj_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  uvj_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `UVJ_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into a full queue")
  `UVJ_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "pop from an empty queue")
  `UVJ_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

### hdl/uvj_front.sv
// Front end: accepts field points and reduces them to magnitudes and a sign class.
module uvj_front (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,
  input  uvj_pkg::uvj_cfg_t  cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output uvj_pkg::uvj_item_t item_o
);
  import uvj_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [COORD_W-1:0]       fx, fy;

  assign fx = s_axis_tdata[31:0];
  assign fy = s_axis_tdata[63:32];

  assign dx = $signed({fx[COORD_W-1], fx}) - $signed({cfg_i.center_x[COORD_W-1], cfg_i.center_x});
  assign dy = $signed({fy[COORD_W-1], fy}) - $signed({cfg_i.center_y[COORD_W-1], cfg_i.center_y});

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // The off-diagonal entry is negative when both offsets are nonzero with equal sign.
  always_comb begin
    item_o.a   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    item_o.b   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    item_o.neg = (dx != '0) && (dy != '0) && (dx[DIFF_W-1] == dy[DIFF_W-1]);
  end

endmodule

### hdl/uvj_back.sv
// Back end: pipelined squares, root, ratio and magnitude division with saturation.
`include "assert_macros.svh"

module uvj_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uvj_pkg::uvj_cfg_t  cfg_i,
  input  logic               fifo_valid_i,
  input  uvj_pkg::uvj_item_t item_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [95:0]        m_axis_tdata,
  output logic               m_axis_tuser
);
  import uvj_pkg::*;

  logic en;
  logic [SUM_W+1:0] sq_a, sq_b, sq_ab;

  logic      p1_vld_q;
  uvj_prod_t p1_q;
  logic      p2_vld_q;
  uvj_sum_t  p2_q;

  uvj_rs_t rs_init;
  logic [2:0] rs_lsb;
  uvj_rs_t rs_q [ROOT_STEPS];
  logic [ROOT_STEPS-1:0] rs_vld_q;

  logic    mg_vld_q;
  uvj_mg_t mg_q;

  uvj_md_t md_init;
  uvj_md_t md_q [MAG_STEPS];
  logic [MAG_STEPS-1:0] md_vld_q;

  logic                  out_vld_q;
  logic [2:0][COORD_W-1:0] out_data_q, out_data_d;
  logic                  out_sat_q, out_sat_d;

  // The whole pipe advances together whenever the output register can take a result.
  assign en    = !out_vld_q || m_axis_tready;
  assign pop_o = en && fifo_valid_i;

  assign sq_a  = {35'b0, item_i.a} * {35'b0, item_i.a};
  assign sq_b  = {35'b0, item_i.b} * {35'b0, item_i.b};
  assign sq_ab = {35'b0, item_i.a} * {35'b0, item_i.b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      mg_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= fifo_valid_i;
      p2_vld_q <= p1_vld_q;
      mg_vld_q <= rs_vld_q[ROOT_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.prod[LANE_XX] <= sq_b[SQ_W-1:0];
      p1_q.prod[LANE_XY] <= sq_ab[SQ_W-1:0];
      p1_q.prod[LANE_YY] <= sq_a[SQ_W-1:0];
      p1_q.neg           <= item_i.neg;
      p2_q.s    <= {1'b0, p1_q.prod[LANE_XX]} + {1'b0, p1_q.prod[LANE_YY]};
      p2_q.prod <= p1_q.prod;
      p2_q.neg  <= p1_q.neg;
      p2_q.zero <= ({1'b0, p1_q.prod[LANE_XX]} + {1'b0, p1_q.prod[LANE_YY]})
                   <= {4'b0, cfg_i.lim_sq};
    end
  end

  // Restoring root and ratio division start from the summed squares.
  always_comb begin
    rs_init.s    = p2_q.s;
    rs_init.srem = '0;
    rs_init.root = '0;
    rs_init.quo  = '0;
    rs_init.neg  = p2_q.neg;
    rs_init.zero = p2_q.zero;
    for (int j = 0; j < 3; j++) begin
      rs_init.drem[j] = {2'b00, p2_q.prod[j][SQ_W-1:1]};
      rs_lsb[j]       = p2_q.prod[j][0];
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_rs
    localparam int I = ROOT_STEPS - 1 - k;
    uvj_rs_t           src, nxt;
    logic              src_vld;
    logic [1:0]        pair;
    logic [2:0]        nbit;
    logic [ROOT_W+3:0] sh, tr;
    logic [SUM_W:0]    dtr;

    if (k == 0) begin : g_first
      assign src     = rs_init;
      assign src_vld = p2_vld_q;
      assign nbit    = rs_lsb;
    end else begin : g_next
      assign src     = rs_q[k-1];
      assign src_vld = rs_vld_q[k-1];
      assign nbit    = 3'b000;
    end

    // Two radicand bits per step; the low 32 radicand bits are zeros.
    if (I >= 16) begin : g_pair
      assign pair = src.s[2*I-31 -: 2];
    end else begin : g_nopair
      assign pair = 2'b00;
    end

    always_comb begin
      nxt = src;
      dtr = '0;
      sh  = {src.srem, pair};
      tr  = {2'b00, src.root, 2'b01};
      if (sh >= tr) begin
        nxt.srem = (ROOT_W+2)'(sh - tr);
        nxt.root = {src.root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.srem = sh[ROOT_W+1:0];
        nxt.root = {src.root[ROOT_W-2:0], 1'b0};
      end
      if (k < RATIO_STEPS) begin
        for (int j = 0; j < 3; j++) begin
          dtr = {src.drem[j], nbit[j]};
          if (dtr >= {1'b0, src.s}) begin
            nxt.drem[j] = SUM_W'(dtr - {1'b0, src.s});
            nxt.quo[j]  = {src.quo[j][RATIO_W-2:0], 1'b1};
          end else begin
            nxt.drem[j] = dtr[SUM_W-1:0];
            nxt.quo[j]  = {src.quo[j][RATIO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rs_vld_q[k] <= 1'b0;
      end else if (en) begin
        rs_vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rs_q[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mg_q.t[j] <= {33'b0, cfg_i.density} * {32'b0, rs_q[ROOT_STEPS-1].quo[j]};
      end
      mg_q.root <= rs_q[ROOT_STEPS-1].root;
      mg_q.neg  <= rs_q[ROOT_STEPS-1].neg;
      mg_q.zero <= rs_q[ROOT_STEPS-1].zero;
    end
  end

  // A quotient of 2^32 or more is flagged at once and clipped at the end.
  always_comb begin
    md_init.root = mg_q.root;
    md_init.q    = '0;
    md_init.neg  = mg_q.neg;
    md_init.zero = mg_q.zero;
    for (int j = 0; j < 3; j++) begin
      md_init.ovf[j] = {16'b0, mg_q.t[j][SCALED_W-1:MAG_W]} >= mg_q.root;
      md_init.rem[j] = md_init.ovf[j] ? '0 : {16'b0, mg_q.t[j][SCALED_W-1:MAG_W]};
      md_init.tlo[j] = mg_q.t[j][MAG_W-1:0];
    end
  end

  for (genvar k = 0; k < MAG_STEPS; k++) begin : g_md
    uvj_md_t         src, nxt;
    logic            src_vld;
    logic [ROOT_W:0] trial;

    if (k == 0) begin : g_first
      assign src     = md_init;
      assign src_vld = mg_vld_q;
    end else begin : g_next
      assign src     = md_q[k-1];
      assign src_vld = md_vld_q[k-1];
    end

    always_comb begin
      nxt   = src;
      trial = '0;
      for (int j = 0; j < 3; j++) begin
        trial      = {src.rem[j], src.tlo[j][MAG_W-1]};
        nxt.tlo[j] = {src.tlo[j][MAG_W-2:0], 1'b0};
        if (trial >= {1'b0, src.root}) begin
          nxt.rem[j] = ROOT_W'(trial - {1'b0, src.root});
          nxt.q[j]   = {src.q[j][MAG_W-2:0], 1'b1};
        end else begin
          nxt.rem[j] = trial[ROOT_W-1:0];
          nxt.q[j]   = {src.q[j][MAG_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        md_vld_q[k] <= 1'b0;
      end else if (en) begin
        md_vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        md_q[k] <= nxt;
      end
    end
  end

  // Clip, apply the sign of the off-diagonal entry and force zeros near the centre.
  always_comb begin
    logic [COORD_W-1:0] lim, mag;
    logic               neg, hit;
    out_sat_d = 1'b0;
    for (int j = 0; j < 3; j++) begin
      neg = (j == LANE_XY) && md_q[MAG_STEPS-1].neg;
      lim = neg ? NEG_LIMIT : POS_LIMIT;
      hit = md_q[MAG_STEPS-1].ovf[j] || (md_q[MAG_STEPS-1].q[j] > lim);
      mag = hit ? lim : md_q[MAG_STEPS-1].q[j];
      out_data_d[j] = neg ? COORD_W'(0 - mag) : mag;
      out_sat_d     = out_sat_d || hit;
      if (md_q[MAG_STEPS-1].zero) begin
        out_data_d[j] = '0;
      end
    end
    if (md_q[MAG_STEPS-1].zero) begin
      out_sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= md_vld_q[MAG_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_sat_q  <= out_sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  `UVJ_ASSERT(a_out_from_pipe, clk_i, rst_ni, $rose(out_vld_q) |-> $past(md_vld_q[MAG_STEPS-1]), "result appeared without a finished item")
  `UVJ_ASSERT(a_sat_at_limit, clk_i, rst_ni, (out_vld_q && out_sat_q) |-> (out_data_q[LANE_XX] == POS_LIMIT || out_data_q[LANE_XY] == POS_LIMIT || out_data_q[LANE_XY] == NEG_LIMIT || out_data_q[LANE_YY] == POS_LIMIT), "saturation flagged with no clipped entry")
  `UVJ_ASSERT(a_diag_positive, clk_i, rst_ni, out_vld_q |-> (!out_data_q[LANE_XX][COORD_W-1] && !out_data_q[LANE_YY][COORD_W-1]), "diagonal entry is negative")

endmodule

### hdl/unit_vector_jacobian_2d_top.sv
// Top level of the density-scaled unit vector Jacobian block for 2-D field points.
//
// Usage: configure the sphere centre, density and near-zero distance limit through
// the configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i, always ready)
// while the block is idle. Field points arrive on the slave stream, one point per
// transaction, with x in tdata bits 31:0 and y in bits 63:32, both signed Q16.16.
// Each point yields exactly one result transaction on the master stream carrying
// the xx, xy and yy entries and a saturation flag in tuser.
// Throughput is one transaction per cycle while the receiver keeps tready high; the
// back end holds the 49 steps of the pipelined square root (which also carry the
// 33-step ratio division) and the 32 steps of the pipelined magnitude division.
// The front end classifies a point in the cycle it is accepted and places it in a
// short queue; the back end drains that queue whenever its output register is free.
// When the receiver stalls, the whole back-end pipe holds, the queue fills and the
// slave-side tready falls once it is full; nothing is lost or repeated.
// Reset empties the queue and pipe and returns the registers to centre zero,
// density 1.0 and a zero distance limit.
module unit_vector_jacobian_2d_top #(
  parameter int unsigned FIFO_DEPTH = uvj_pkg::UVJ_FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uvj_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // field_x, field_y
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // jac_xx, jac_xy, jac_yy
  output logic                           m_axis_tuser   // saturated
);
  import uvj_pkg::*;

  logic [COORD_W-1:0] center_x_q, center_y_q, density_q;
  logic [LIM_W-1:0]   near_lim_q;
  logic [LIMSQ_W-1:0] lim_sq_q;
  uvj_cfg_t           cfg;

  logic      push, full, pop, fifo_valid;
  uvj_item_t front_item, fifo_item;

  // The configuration channel never stalls; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      density_q  <= DENSITY_RESET;
      near_lim_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_DENSITY:  density_q  <= cfg_data_i;
        CFG_NEAR_LIM: near_lim_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The squared limit is kept ready so the near-centre test is a single compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_sq_q <= '0;
    end else begin
      lim_sq_q <= {31'b0, near_lim_q} * {31'b0, near_lim_q};
    end
  end

  always_comb begin
    cfg.center_x = center_x_q;
    cfg.center_y = center_y_q;
    cfg.density  = density_q;
    cfg.lim_sq   = lim_sq_q;
  end

  uvj_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_i         (cfg),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  uvj_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (fifo_item),
    .valid_o (fifo_valid)
  );

  uvj_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fifo_valid_i  (fifo_valid),
    .item_i        (fifo_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### sim/unit_vector_jacobian_2d_checker.sv
// Checker for the unit vector Jacobian block: predicts each result and compares it.
`timescale 1ns / 100ps

module unit_vector_jacobian_2d_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [uvj_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [63:0]                   s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [95:0]                   m_tdata_i,
  input  logic                          m_tuser_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import uvj_pkg::*;

  typedef struct packed {
    logic [31:0] xx;
    logic [31:0] xy;
    logic [31:0] yy;
    logic        sat;
  } jacobian_t;

  jacobian_t   jacobian_q[$];
  logic [31:0] centre_x, centre_y, dens;
  logic [30:0] near_lim;

  // Magnitude of one entry with sign and clipping applied.
  function automatic logic [31:0] entry_value(logic [127:0] prod, logic [127:0] sum,
                                              logic [127:0] root, logic neg,
                                              inout logic sat);
    logic [127:0] ratio, mag, clip;
    ratio = (prod << 32) / sum;
    mag   = ({96'd0, dens} * ratio) / root;
    clip  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > clip) begin
      sat = 1'b1;
      mag = clip;
    end
    return neg ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic jacobian_t predict_jacobian(logic [31:0] fx, logic [31:0] fy);
    logic signed [33:0] dx, dy;
    logic [127:0]       a, b, sum, rad, root, cand;
    logic               neg, sat;
    jacobian_t          res;
    dx   = $signed({{2{fx[31]}}, fx}) - $signed({{2{centre_x[31]}}, centre_x});
    dy   = $signed({{2{fy[31]}}, fy}) - $signed({{2{centre_y[31]}}, centre_y});
    a    = {94'd0, (dx < 0) ? -dx : dx};
    b    = {94'd0, (dy < 0) ? -dy : dy};
    sum  = a * a + b * b;
    res  = '0;
    sat  = 1'b0;
    if ({97'd0, near_lim} * {97'd0, near_lim} >= sum) return res;
    rad  = sum << 32;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= rad) root = cand;
    end
    neg    = (dx > 0 && dy > 0) || (dx < 0 && dy < 0);
    res.xx = entry_value(b * b, sum, root, 1'b0, sat);
    res.xy = entry_value(a * b, sum, root, neg, sat);
    res.yy = entry_value(a * a, sum, root, 1'b0, sat);
    res.sat = sat;
    return res;
  endfunction

  assign pending_o = jacobian_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    jacobian_t want, got;
    if (!rst_ni) begin
      jacobian_q.delete();
      centre_x     <= '0;
      centre_y     <= '0;
      dens         <= DENSITY_RESET;
      near_lim     <= '0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        jacobian_q.push_back(predict_jacobian(s_tdata_i[31:0], s_tdata_i[63:32]));
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[31:0], m_tdata_i[63:32], m_tdata_i[95:64], m_tuser_i};
        checked_o <= checked_o + 1;
        if (jacobian_q.size() == 0) begin
          if (fail_count_o < 10) $display("result with nothing expected: %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = jacobian_q.pop_front();
          if (want !== got) begin
            if (fail_count_o < 10)
              $display("mismatch: xx %h/%h xy %h/%h yy %h/%h sat %b/%b (exp/act)",
                       want.xx, got.xx, want.xy, got.xy, want.yy, got.yy,
                       want.sat, got.sat);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CENTER_X: centre_x <= cfg_data_i;
          CFG_CENTER_Y: centre_y <= cfg_data_i;
          CFG_DENSITY:  dens     <= cfg_data_i;
          CFG_NEAR_LIM: near_lim <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### sim/unit_vector_jacobian_2d_top_tb.sv
// Testbench top for the unit vector Jacobian block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module unit_vector_jacobian_2d_top_tb;
  import uvj_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;   // field_x, field_y
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [95:0]          m_axis_tdata;        // jac_xx, jac_xy, jac_yy
  logic                 m_axis_tuser;        // saturated

  int fail_count, pending, checked;
  int points_sent  = 0;
  int burst_left   = 0;
  int hold_cycles  = 0;   // receiver hold-off requested by the stimulus
  logic [31:0] centre_x = '0, centre_y = '0;
  logic [30:0] near_lim = '0;

  // The clock toggles every half period of 5 ns.
  always #5 clk_i = ~clk_i;

  unit_vector_jacobian_2d_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  unit_vector_jacobian_2d_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  // The receiver follows a stall pattern chosen at random, from never stalling
  // to stalling most of the time. A requested hold-off overrides it.
  always @(posedge clk_i) begin
    static int rx_mode = 0;
    static int rx_tick = 0;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    rx_tick++;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Waits for the transaction of a held valid. Ready is looked at on the falling edge,
  // well away from the rising edge at which both sides update.
  task automatic wait_accept(input bit is_cfg);
    forever begin
      @(negedge clk_i);
      if (is_cfg ? cfg_ready_o : s_axis_tready) begin
        @(posedge clk_i);
        break;
      end
    end
  endtask

  // Register writes are made only once every result is in, after a latency margin.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    wait_accept(1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CENTER_X: centre_x = val;
      CFG_CENTER_Y: centre_y = val;
      CFG_NEAR_LIM: near_lim = val[30:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] dens, input logic [30:0] lim);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_DENSITY, dens);
    write_reg(CFG_NEAR_LIM, {1'b0, lim});
  endtask

  // Offers one field point. Points go out in bursts of random length; between bursts
  // valid drops for a random gap, and a zero gap keeps valid high throughout.
  task automatic send_point(input logic [31:0] fx, input logic [31:0] fy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fy, fx};
    wait_accept(1'b0);
    points_sent++;
  endtask

  // A random offset of random magnitude, so that both near and far points occur.
  function automatic logic [31:0] rand_offset();
    int sh;
    sh = $urandom_range(0, 31);
    return $urandom() >> sh;
  endfunction

  task automatic send_random_point();
    logic [31:0] ox, oy;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      send_point($urandom(), $urandom());
    end else if (pick < 8) begin
      ox = rand_offset();
      oy = rand_offset();
      send_point(centre_x + ($urandom_range(0, 1) ? ox : -ox),
                 centre_y + ($urandom_range(0, 1) ? oy : -oy));
    end else begin
      // Around the distance limit, along an axis or on a diagonal.
      ox = {1'b0, near_lim} + $urandom_range(0, 2) - 1;
      oy = $urandom_range(0, 1) ? ox : $urandom_range(0, 3);
      send_point(centre_x + ox, centre_y - oy);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset settings: the centre itself, the four sign
    // quadrants, points on the axes and the coordinate extremes.
    send_point(32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'h0001_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'hFFFF_0000, 32'hFFFF_0000);
    send_point(32'h0003_0000, 32'h0);
    send_point(32'h0, 32'hFFFD_0000);
    send_point(32'h1, 32'h1);
    send_point(32'h1, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h0);
    // A write to an index outside the register list must change nothing.
    write_reg(CFG_NEAR_LIM + 8'd1, 32'hFFFF_FFFF);
    send_point(32'h0002_0000, 32'h0001_0000);
    // Opposite extreme centre, largest density and a small distance limit.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0100);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0100, 32'h7FFF_FFFF);
    send_point(32'h8000_0101, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0001, 32'h7FFF_FFFE);
    send_point(32'h8000_00B5, 32'h7FFF_FF4A);
    // Zero density and the largest limit.
    configure(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000);
    write_reg(CFG_NEAR_LIM, 32'h0);
    send_point(32'h0001_0000, 32'hFFFF_0000);

    // Random phases, each under its own settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure($urandom(), $urandom(), DENSITY_RESET, 31'h0);
        1: configure($urandom(), $urandom(), $urandom(), 31'($urandom_range(0, 31'hFFFF)));
        2: configure(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        3: configure(32'h0, 32'h0, $urandom() >> 8,
                     31'($urandom() >> $urandom_range(1, 31)));
        default: configure($urandom(), $urandom(), $urandom(), 31'($urandom()));
      endcase
      for (int n = 0; n < 100; n++) begin
        // A long receiver hold-off while points keep coming fills the block.
        if (n == 20 && ph % 2 == 0) hold_cycles = 400;
        send_random_point();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d field points over ten register settings, %0d results checked,",
             points_sent, checked);
    $display("with bursty input, varied output stalls and full back-pressure.");
    if (fail_count == 0) begin
      $display("unit_vector_jacobian_2d_top_tb passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("unit_vector_jacobian_2d_top_tb failed");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #3_000_000;
    $display("timeout");
    $display("unit_vector_jacobian_2d_top_tb failed");
    $finish;
  end

endmodule
